// ===== src/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometric pressure compensation core.
// ----------------------------------------------------------------------------
`default_nettype none
package bpc_pkg;

    localparam int unsigned APB_ADDR_W = 5;
    localparam logic [APB_ADDR_W-1:0] ADDR_TEMP_COEF  = 5'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_PRES_COEF  = 5'd8;
    localparam logic [APB_ADDR_W-1:0] ADDR_SECOND_COEF = 5'd16;
    localparam logic [APB_ADDR_W-1:0] ADDR_OSS        = 5'd24;

    localparam logic CMD_TEMP     = 1'b0;
    localparam logic CMD_PRESSURE = 1'b1;

    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] X3_BIAS    = 32'd32768;
    localparam logic [31:0] B7_SCALE   = 32'd50000;
    localparam logic [31:0] P_COEF_SQ  = 32'd3038;
    localparam logic [31:0] P_COEF_LIN = 32'hFFFF_E343; // -7357
    localparam logic [31:0] P_BIAS     = 32'd3791;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_MUL,
        ST_T_DEN,
        ST_T_DIV,
        ST_T_END,
        ST_P_B6SQ,
        ST_P_X1A,
        ST_P_X2A,
        ST_P_B3,
        ST_P_X1B,
        ST_P_X2B,
        ST_P_B4,
        ST_P_B7,
        ST_P_LAUNCH,
        ST_P_DIV,
        ST_P_H2,
        ST_P_X1C,
        ST_P_X2C,
        ST_P_END,
        ST_OUT
    } state_t;

    // divider control
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/bpc_divider.sv =====
// ----------------------------------------------------------------------------
// bpc_divider
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bpc_divider
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bpc_pkg::div_req_t req,
    output bpc_pkg::div_rsp_t      rsp
);
    import bpc_pkg::*;

    logic [31:0] quot_reg, quot_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvsr_reg, dvsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quot_reg[31]};
        trial     = shifted - {1'b0, dvsr_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next  = trial[31:0];
                quot_next = {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[31:0];
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule
`default_nettype wire

// ===== src/barometric_pressure_compensation_core.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core
// Integer compensation of raw barometer temperature and pressure conversions.
// ----------------------------------------------------------------------------
// A transaction runs from acceptance to the result on the master side; a zero
// divisor ends it early, with divide_error set in the result. The sequence is
// the run of the shared divider (a start step, the quotient steps and a done
// step) plus one state for each step of the single 32x32 multiplier that the
// sequencer reuses for every product.
// The slave side is ready only while the core is idle and no result waits; it
// is ready again in the cycle after the result is taken. A temperature
// transaction without a zero divisor updates the stored b5 term, which later
// pressure transactions use.
`default_nettype none
module barometric_pressure_compensation_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bpc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [63:0]                     pwdata,
    output logic [63:0]                          prdata,
    output logic                                 pready,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [23:0]                     s_tdata,  // raw_sample[23:0]
    input  wire logic                            s_tuser,  // command
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [39:0]                          m_tdata,  // value[31:0], divide_error, pad
    output logic                                 m_tuser   // kind
);
    import bpc_pkg::*;

    logic [63:0] tcoef_reg;
    logic [63:0] pcoef_reg;
    logic [31:0] scoef_reg;
    logic [1:0]  oss_reg;
    logic [31:0] b5_reg, b5_next;

    state_t      state_reg, state_next;
    logic        cmd_reg, cmd_next;
    logic [23:0] raw_reg, raw_next;
    logic [31:0] x1_reg, x1_next;
    logic [31:0] b6_reg, b6_next;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] b3_reg, b3_next;
    logic [31:0] b4_reg, b4_next;
    logic [31:0] p_reg, p_next;
    logic        neg_reg, neg_next;
    logic        dstart_reg, dstart_next;
    logic [31:0] val_reg, val_next;
    logic        err_reg, err_next;
    logic        ovalid_reg, ovalid_next;

    logic [31:0] mul_a, mul_b, mul_p;
    logic [31:0] prod_reg;
    logic [31:0] dvd_reg, dvd_next, dvs_reg, dvs_next;
    div_req_t    dreq;
    div_rsp_t    drsp;

    logic        cfg_wr;
    logic [31:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2;
    logic [31:0] up, t32, qn;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    assign ac5 = {16'd0, tcoef_reg[15:0]};
    assign ac6 = {16'd0, tcoef_reg[31:16]};
    assign mc  = sx16(tcoef_reg[47:32]);
    assign md  = sx16(tcoef_reg[63:48]);
    assign ac1 = sx16(pcoef_reg[15:0]);
    assign ac2 = sx16(pcoef_reg[31:16]);
    assign ac3 = sx16(pcoef_reg[47:32]);
    assign ac4 = {16'd0, pcoef_reg[63:48]};
    assign b1  = sx16(scoef_reg[15:0]);
    assign b2  = sx16(scoef_reg[31:16]);
    assign up  = {8'd0, raw_reg} >> (4'd8 - {2'd0, oss_reg});

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcoef_reg <= '0;
            pcoef_reg <= '0;
            scoef_reg <= '0;
            oss_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_TEMP_COEF:   tcoef_reg <= pwdata;
                ADDR_PRES_COEF:   pcoef_reg <= pwdata;
                ADDR_SECOND_COEF: scoef_reg <= pwdata[31:0];
                ADDR_OSS:         oss_reg   <= pwdata[1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_TEMP_COEF:   prdata = tcoef_reg;
            ADDR_PRES_COEF:   prdata = pcoef_reg;
            ADDR_SECOND_COEF: prdata = {32'd0, scoef_reg};
            ADDR_OSS:         prdata = {62'd0, oss_reg};
            default:          prdata = '0;
        endcase
    end

    // shared multiplier, operands picked by state, product registered
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_T_MUL:  begin mul_a = {16'd0, raw_reg[15:0]} - ac6; mul_b = ac5; end
            ST_P_B6SQ: begin mul_a = b6_reg; mul_b = b6_reg; end
            ST_P_X1A:  begin mul_a = b2;     mul_b = asr(prod_reg, 5'd12); end
            ST_P_X2A:  begin mul_a = ac2;    mul_b = b6_reg; end
            ST_P_B3:   begin mul_a = ac3;    mul_b = b6_reg; end
            ST_P_X1B:  begin mul_a = b1;     mul_b = sq_reg; end
            ST_P_B4:   begin mul_a = ac4;    mul_b = acc_reg + X3_BIAS; end
            ST_P_B7:   begin mul_a = up - b3_reg; mul_b = B7_SCALE >> oss_reg; end
            ST_P_H2:   begin mul_a = asr(p_reg, 5'd8); mul_b = asr(p_reg, 5'd8); end
            ST_P_X1C:  begin mul_a = prod_reg; mul_b = P_COEF_SQ; end
            ST_P_X2C:  begin mul_a = P_COEF_LIN; mul_b = p_reg; end
            default:   ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
    end

    assign dreq.start    = dstart_reg;
    assign dreq.dividend = dvd_reg;
    assign dreq.divisor  = dvs_reg;

    bpc_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'd0, err_reg, val_reg};
    assign m_tuser  = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            b5_reg     <= '0;
            ovalid_reg <= 1'b0;
            dstart_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            b5_reg     <= b5_next;
            ovalid_reg <= ovalid_next;
            dstart_reg <= dstart_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        raw_reg <= raw_next;
        x1_reg  <= x1_next;
        b6_reg  <= b6_next;
        sq_reg  <= sq_next;
        acc_reg <= acc_next;
        b3_reg  <= b3_next;
        b4_reg  <= b4_next;
        p_reg   <= p_next;
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        val_reg <= val_next;
        err_reg <= err_next;
    end

    // each state consumes the product of the operands chosen in the state before
    always_comb
    begin
        state_next  = state_reg;
        b5_next     = b5_reg;
        ovalid_next = ovalid_reg;
        dstart_next = 1'b0;
        cmd_next    = cmd_reg;
        raw_next    = raw_reg;
        x1_next     = x1_reg;
        b6_next     = b6_reg;
        sq_next     = sq_reg;
        acc_next    = acc_reg;
        b3_next     = b3_reg;
        b4_next     = b4_reg;
        p_next      = p_reg;
        neg_next    = neg_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        val_next    = val_reg;
        err_next    = err_reg;
        t32         = '0;
        qn          = neg_reg ? (32'd0 - drsp.quotient) : drsp.quotient;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    raw_next   = s_tdata;
                    b6_next    = b5_reg - B6_OFFSET;
                    state_next = (s_tuser == CMD_TEMP) ? ST_T_MUL : ST_P_B6SQ;
                end
            end
            ST_T_MUL: state_next = ST_T_DEN;
            ST_T_DEN:
            begin
                x1_next = asr(prod_reg, 5'd15);
                t32     = asr(prod_reg, 5'd15) + md;
                if (t32 == 32'd0)
                begin
                    val_next    = '0;
                    err_next    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_OUT;
                end
                else
                begin
                    neg_next    = mc[31] ^ t32[31];
                    dvd_next    = mc[31] ? (32'd0 - (mc << 11)) : (mc << 11);
                    dvs_next    = t32[31] ? (32'd0 - t32) : t32;
                    dstart_next = 1'b1;
                    state_next  = ST_T_DIV;
                end
            end
            ST_T_DIV:
            begin
                if (drsp.done)
                begin
                    state_next = ST_T_END;
                end
            end
            ST_T_END:
            begin
                b5_next     = x1_reg + qn;
                val_next    = asr(x1_reg + qn + 32'd8, 5'd4);
                err_next    = 1'b0;
                ovalid_next = 1'b1;
                state_next  = ST_OUT;
            end
            ST_P_B6SQ: state_next = ST_P_X1A;
            ST_P_X1A:
            begin
                sq_next    = asr(prod_reg, 5'd12);
                state_next = ST_P_X2A;
            end
            ST_P_X2A:
            begin
                acc_next   = asr(prod_reg, 5'd11);
                state_next = ST_P_B3;
            end
            ST_P_B3:
            begin
                t32        = acc_reg + asr(prod_reg, 5'd11);
                b3_next    = asr((((ac1 << 2) + t32) << oss_reg) + 32'd2, 5'd2);
                state_next = ST_P_X1B;
            end
            ST_P_X1B:
            begin
                acc_next   = asr(prod_reg, 5'd13);
                state_next = ST_P_X2B;
            end
            ST_P_X2B:
            begin
                acc_next   = asr(acc_reg + asr(prod_reg, 5'd16) + 32'd2, 5'd2);
                state_next = ST_P_B4;
            end
            ST_P_B4: state_next = ST_P_B7;
            ST_P_B7:
            begin
                b4_next    = prod_reg >> 15;
                state_next = ST_P_LAUNCH;
            end
            ST_P_LAUNCH:
            begin
                // product here is b7; large values are divided first, doubled after
                if (b4_reg == 32'd0)
                begin
                    val_next    = '0;
                    err_next    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_OUT;
                end
                else
                begin
                    neg_next    = prod_reg[31];
                    dvd_next    = prod_reg[31] ? prod_reg : (prod_reg << 1);
                    dvs_next    = b4_reg;
                    dstart_next = 1'b1;
                    state_next  = ST_P_DIV;
                end
            end
            ST_P_DIV:
            begin
                if (drsp.done)
                begin
                    p_next     = neg_reg ? (drsp.quotient << 1) : drsp.quotient;
                    state_next = ST_P_H2;
                end
            end
            ST_P_H2:  state_next = ST_P_X1C;
            ST_P_X1C: state_next = ST_P_X2C;
            ST_P_X2C:
            begin
                acc_next   = asr(prod_reg, 5'd16);
                state_next = ST_P_END;
            end
            ST_P_END:
            begin
                val_next    = p_reg + asr(acc_reg + asr(prod_reg, 5'd16) + P_BIAS, 5'd4);
                err_next    = 1'b0;
                ovalid_next = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    ovalid_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // results only leave while a result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (state_reg == ST_OUT))
        else $error("result valid outside output state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result appeared in the cycle after acceptance");

    assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == ST_T_DIV || state_reg == ST_P_DIV))
        else $error("divider finished outside a divide step");

    assert property (@(posedge clk) disable iff (!rst_n)
        dstart_reg |-> !drsp.busy)
        else $error("divider started while busy");

endmodule
`default_nettype wire
